### rtl/assert_macros.svh
// Assertion helpers for the particle pool
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define PPE_ASSERT_IMP(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("assertion failed");
`define PPE_ASSERT_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed");
`else
`define PPE_ASSERT_IMP(label, clk, rst, pre, post)
`define PPE_ASSERT_NEXT(label, clk, rst, pre, post)
`endif
`endif

### rtl/ppe_pkg.sv
package ppe_pkg;
  localparam int unsigned POOL_SLOTS_DEF = 32;

  localparam logic [1:0] REQ_ADD   = 2'd0;
  localparam logic [1:0] REQ_TICK  = 2'd1;
  localparam logic [1:0] REQ_DRAW  = 2'd2;
  localparam logic [1:0] REQ_CLEAR = 2'd3;

  localparam logic [1:0] ST_DONE   = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_RECORD = 2'd2;
  localparam logic [1:0] ST_NONE   = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE, S_DIV, S_WAIT, S_SCAN, S_MUL, S_DEC, S_DAMP, S_EMIT
  } state_t;

  // one particle record as held in the slot memory
  typedef struct packed {
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] pz;
    logic [31:0] vx;
    logic [31:0] vy;
    logic [31:0] vz;
    logic [15:0] life;
    logic [15:0] age;
    logic [15:0] size;
    logic [23:0] rgb;
  } slot_t;

  // result item
  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [23:0] rgb;
    logic [16:0] size;
    logic        last;
  } result_t;
endpackage

### rtl/ppe_slot_mem.sv
module ppe_slot_mem #(
  parameter int unsigned SLOTS = ppe_pkg::POOL_SLOTS_DEF,
  localparam int unsigned AW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  ppe_pkg::slot_t    wdata,
  input  logic [AW-1:0]     raddr,
  output ppe_pkg::slot_t    rdata
);
  ppe_pkg::slot_t mem [SLOTS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### rtl/ppe_divider.sv
// Fade divider: q = floor(num*65536/den), num <= den, one quotient bit per cycle.
module ppe_divider (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [15:0] num,
  input  logic [15:0] den,
  output logic        done,
  output logic [16:0] quo
);
  logic [16:0] rem;
  logic [4:0]  cnt;
  logic        busy;
  logic [17:0] trial;

  assign trial = {rem, 1'b0} - {2'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 5'd0;
      end else if (busy) begin
        if (cnt == 5'd16) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      // first bit: num >= den gives quotient bit 16
      if (num >= den) begin
        rem <= {1'b0, num - den};
        quo <= 17'd1;
      end else begin
        rem <= {1'b0, num};
        quo <= 17'd0;
      end
    end else if (busy && cnt != 5'd16) begin
      if (!trial[17]) begin
        rem <= trial[16:0];
        quo <= {quo[15:0], 1'b1};
      end else begin
        rem <= {rem[15:0], 1'b0};
        quo <= {quo[15:0], 1'b0};
      end
    end
  end
endmodule

### rtl/particle_pool_engine.sv
// Particle pool: slot records live in one synchronous RAM, live bits in flops.
// Add, clear: result valid the cycle after the transfer. Tick skips free slots,
// frees expiring ones, moves, damps and writes back the rest, then gives the single
// result. Draw fades each live slot with the serial divider; output stalls hold it;
// records go out one behind so the final one carries last. One request in flight;
// the next transfer waits for the final result. rst clears live bits and drag_rate.
`include "assert_macros.svh"
module particle_pool_engine #(
  parameter int unsigned POOL_SLOTS = ppe_pkg::POOL_SLOTS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         req_type,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  input  logic signed [31:0] vel_x,
  input  logic signed [31:0] vel_y,
  input  logic signed [31:0] vel_z,
  input  logic [15:0]        lifetime,
  input  logic [15:0]        point_size,
  input  logic [23:0]        colour_rgb,
  input  logic [15:0]        elapsed,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         status,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_z,
  output logic [23:0]        faded_rgb,
  output logic [16:0]        draw_size,
  output logic               last
);
  localparam int unsigned AW = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
  localparam int unsigned CW = $clog2(POOL_SLOTS + 1);

  logic [15:0] drag_rate;
  logic [POOL_SLOTS-1:0] live;
  ppe_pkg::state_t state, state_next;

  logic [1:0]  req;
  logic [15:0] el;
  logic [16:0] kf;          // damping factor Q1.16, 0..65536
  logic [CW-1:0] idx;       // slot cursor
  logic [AW-1:0] slot;
  logic          any;       // draw holds at least one record
  ppe_pkg::slot_t rd, cur, cur_next;
  ppe_pkg::result_t res, held, rec, emit_res;
  logic res_full;

  assign slot = idx[AW-1:0];

  // ---------------- configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      drag_rate <= '0;
    end else if (cfg_we) begin
      drag_rate <= cfg_wdata;
    end
  end

  // ---------------- lowest free slot for add
  logic [AW-1:0] free_idx;
  logic          free_ok;
  always_comb begin
    free_idx = '0;
    free_ok  = 1'b0;
    for (int i = POOL_SLOTS - 1; i >= 0; i--) begin
      if (!live[i]) begin
        free_idx = AW'(i);
        free_ok  = 1'b1;
      end
    end
  end

  logic accept;
  assign in_stall = (state != ppe_pkg::S_IDLE) || res_full;
  assign accept   = in_valid && !in_stall;

  // ---------------- tick arithmetic on the current record
  logic [16:0] age_sum;
  logic [15:0] age_new;
  logic signed [48:0] prod [3];
  logic signed [31:0] pnew;
  logic signed [31:0] vdamp;
  logic signed [31:0] vin  [3];
  logic signed [31:0] pin  [3];
  logic signed [49:0] psum;
  logic [31:0] mag;
  logic [48:0] dprod;
  logic [1:0]  lane;        // axis serviced in S_DAMP / S_MUL

  assign vin[0] = cur.vx;
  assign vin[1] = cur.vy;
  assign vin[2] = cur.vz;
  assign pin[0] = cur.px;
  assign pin[1] = cur.py;
  assign pin[2] = cur.pz;

  assign age_sum = {1'b0, rd.age} + {1'b0, el};
  assign age_new = age_sum[16] ? 16'hFFFF : age_sum[15:0];

  // position: one 32x17 product per axis, lane by lane
  logic signed [48:0] lane_prod;
  assign lane_prod = vin[lane] * $signed({1'b0, el});
  assign psum = 50'(pin[lane]) + 50'(prod[lane]);
  always_comb begin
    if (psum > 50'sd2147483647) begin
      pnew = 32'sh7FFFFFFF;
    end else if (psum < -50'sd2147483648) begin
      pnew = 32'sh80000000;
    end else begin
      pnew = psum[31:0];
    end
  end
  // velocity damping: magnitude times k, truncated toward zero
  assign mag   = vin[lane][31] ? 32'(-vin[lane]) : vin[lane];
  assign dprod = {17'b0, mag} * {32'b0, kf};
  assign vdamp = vin[lane][31] ? -32'(dprod[47:16]) : 32'(dprod[47:16]);

  // record update: load from RAM in S_WAIT, one axis per S_DAMP
  always_comb begin
    cur_next = cur;
    if (state == ppe_pkg::S_WAIT) begin
      cur_next = rd;
      if (req == ppe_pkg::REQ_TICK) begin
        cur_next.age = age_new;
      end
    end else if (state == ppe_pkg::S_DAMP) begin
      case (lane)
        2'd0: begin
          cur_next.px = pnew;
          cur_next.vx = vdamp;
        end
        2'd1: begin
          cur_next.py = pnew;
          cur_next.vy = vdamp;
        end
        default: begin
          cur_next.pz = pnew;
          cur_next.vz = vdamp;
        end
      endcase
    end
  end

  // ---------------- fade divider and draw products
  logic div_start, div_done;
  logic [16:0] fade;
  logic [16:0] div_q;
  logic [15:0] div_num;
  assign div_num = (cur.age < cur.life) ? (cur.life - cur.age) : 16'd0;

  ppe_divider u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (div_num),
    .den  (cur.life),
    .done (div_done),
    .quo  (div_q)
  );

  logic [24:0] cr, cg, cb;
  logic [32:0] sz;
  assign cr = cur.rgb[23:16] * fade;
  assign cg = cur.rgb[15:8]  * fade;
  assign cb = cur.rgb[7:0]   * fade;
  assign sz = cur.size * (17'd32768 + fade);

  assign rec = '{status: ppe_pkg::ST_RECORD, x: cur.px, y: cur.py, z: cur.pz,
                 rgb: {cr[23:16], cg[23:16], cb[23:16]}, size: sz[32:16],
                 last: 1'b0};

  // closing result: held record with last, scan found none, or done
  always_comb begin
    emit_res = '{status: ppe_pkg::ST_DONE, x: '0, y: '0, z: '0, rgb: '0,
                 size: '0, last: 1'b1};
    if (req == ppe_pkg::REQ_DRAW) begin
      if (any) begin
        emit_res      = held;
        emit_res.last = 1'b1;
      end else begin
        emit_res.status = ppe_pkg::ST_NONE;
      end
    end
  end

  // ---------------- memory port control
  logic           mem_we;
  logic [AW-1:0]  mem_waddr;
  ppe_pkg::slot_t mem_wdata;

  ppe_slot_mem #(.SLOTS(POOL_SLOTS)) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(slot),
    .rdata(rd)
  );

  logic last_slot;
  assign last_slot = (idx == CW'(POOL_SLOTS - 1));

  // next-state
  always_comb begin
    state_next = state;
    unique case (state)
      ppe_pkg::S_IDLE: begin
        if (accept && (req_type == ppe_pkg::REQ_TICK || req_type == ppe_pkg::REQ_DRAW)) begin
          state_next = ppe_pkg::S_SCAN;
        end
      end
      ppe_pkg::S_SCAN: begin
        if (!live[slot]) begin
          state_next = last_slot ? ppe_pkg::S_EMIT : ppe_pkg::S_SCAN;
        end else begin
          state_next = ppe_pkg::S_WAIT;
        end
      end
      ppe_pkg::S_WAIT: begin
        if (req == ppe_pkg::REQ_TICK) begin
          state_next = (age_new >= rd.life) ? (last_slot ? ppe_pkg::S_EMIT : ppe_pkg::S_SCAN)
                                            : ppe_pkg::S_MUL;
        end else begin
          state_next = ppe_pkg::S_DIV;
        end
      end
      ppe_pkg::S_MUL:  state_next = ppe_pkg::S_DAMP;
      ppe_pkg::S_DAMP: begin
        if (lane == 2'd2) begin
          state_next = ppe_pkg::S_DEC;
        end else begin
          state_next = ppe_pkg::S_MUL;
        end
      end
      ppe_pkg::S_DIV: begin
        if (div_done) begin
          state_next = ppe_pkg::S_DEC;
        end
      end
      ppe_pkg::S_DEC: begin
        if (req == ppe_pkg::REQ_TICK || !any || !res_full) begin
          state_next = last_slot ? ppe_pkg::S_EMIT : ppe_pkg::S_SCAN;
        end
      end
      ppe_pkg::S_EMIT: begin
        if (!res_full) begin
          state_next = ppe_pkg::S_IDLE;
        end
      end
      default: state_next = ppe_pkg::S_IDLE;
    endcase
  end

  // outputs of the sequencer
  logic div_kick;
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = slot;
    mem_wdata = cur;
    div_start = 1'b0;
    unique case (state)
      ppe_pkg::S_IDLE: begin
        if (accept && req_type == ppe_pkg::REQ_ADD && free_ok) begin
          mem_we    = 1'b1;
          mem_waddr = free_idx;
          mem_wdata = '{px: pos_x, py: pos_y, pz: pos_z, vx: vel_x, vy: vel_y,
                        vz: vel_z, life: lifetime, age: 16'd0, size: point_size,
                        rgb: colour_rgb};
        end
      end
      ppe_pkg::S_DIV: begin
        // first cycle in S_DIV: record is in cur, kick the divider
        div_start = div_kick;
      end
      ppe_pkg::S_DEC: begin
        if (req == ppe_pkg::REQ_TICK) begin
          mem_we = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ppe_pkg::S_IDLE;
      live     <= '0;
      res_full <= 1'b0;
      div_kick <= 1'b0;
    end else begin
      state    <= state_next;
      div_kick <= 1'b0;
      if (res_full && !out_stall) begin
        res_full <= 1'b0;
      end
      unique case (state)
        ppe_pkg::S_IDLE: begin
          if (accept) begin
            req <= req_type;
            el  <= elapsed;
            idx <= '0;
            any <= 1'b0;
            res <= '{status: (req_type == ppe_pkg::REQ_ADD && !free_ok) ? ppe_pkg::ST_FULL
                                                                       : ppe_pkg::ST_DONE,
                     x: '0, y: '0, z: '0, rgb: '0, size: '0, last: 1'b1};
            if (req_type == ppe_pkg::REQ_ADD) begin
              res_full <= 1'b1;
              if (free_ok) begin
                live[free_idx] <= 1'b1;
              end
            end else if (req_type == ppe_pkg::REQ_CLEAR) begin
              res_full <= 1'b1;
              live     <= '0;
            end
            if ({16'b0, drag_rate} * {16'b0, elapsed} >= 32'd65536) begin
              kf <= '0;
            end else begin
              kf <= 17'd65536 - 17'(drag_rate * elapsed);
            end
          end
        end
        ppe_pkg::S_SCAN: begin
          if (!live[slot]) begin
            if (!last_slot) begin
              idx <= idx + CW'(1);
            end
          end
        end
        ppe_pkg::S_WAIT: begin
          cur  <= cur_next;
          lane <= 2'd0;
          if (req == ppe_pkg::REQ_TICK) begin
            if (age_new >= rd.life) begin
              live[slot] <= 1'b0;
              if (!last_slot) begin
                idx <= idx + CW'(1);
              end
            end
          end else begin
            div_kick <= 1'b1;
          end
        end
        ppe_pkg::S_MUL: begin
          prod[lane] <= lane_prod;
        end
        ppe_pkg::S_DAMP: begin
          lane <= lane + 2'd1;
          cur  <= cur_next;
        end
        ppe_pkg::S_DIV: begin
          if (div_done) begin
            // zero lifetime leaves nothing to fade
            fade <= (cur.age < cur.life) ? div_q : 17'd0;
          end
        end
        ppe_pkg::S_DEC: begin
          if (req == ppe_pkg::REQ_TICK) begin
            if (!last_slot) begin
              idx <= idx + CW'(1);
            end
          end else if (!any || !res_full) begin
            // previous record goes out, the new one waits for the last flag
            held <= rec;
            any  <= 1'b1;
            if (any) begin
              res      <= held;
              res_full <= 1'b1;
            end
            if (!last_slot) begin
              idx <= idx + CW'(1);
            end
          end
        end
        ppe_pkg::S_EMIT: begin
          if (!res_full) begin
            res_full <= 1'b1;
            res      <= emit_res;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid = res_full;
  assign status    = res.status;
  assign out_x     = res.x;
  assign out_y     = res.y;
  assign out_z     = res.z;
  assign faded_rgb = res.rgb;
  assign draw_size = res.size;
  assign last      = res.last;

  `PPE_ASSERT_IMP(a_stall_busy, clk, rst, state != ppe_pkg::S_IDLE, in_stall)
  `PPE_ASSERT_NEXT(a_clear_empties, clk, rst, accept && req_type == ppe_pkg::REQ_CLEAR, live == '0)
  `PPE_ASSERT_IMP(a_last_done, clk, rst, out_valid && status != ppe_pkg::ST_RECORD, last)
endmodule
